// File: design/tgtw_pkg.sv
// Shared types and constants for the text grid terminal writer.
// No dependencies; imported by every module of the block.
package tgtw_pkg;

  localparam int unsigned COLUMNS_DEF = 64;
  localparam int unsigned ROWS_DEF    = 18;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned TAB_STEP    = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT  = 2'd0,
    MODE_READ = 2'd1,
    MODE_ACK  = 2'd2,
    MODE_NONE = 2'd3
  } tgtw_mode_e;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // Grid command issued by the cursor logic for one committed item.
  typedef struct packed {
    logic ld;
    logic wr;
    logic clr_row;
    logic clr_all;
    logic rd;
  } tgtw_gcmd_t;

endpackage

// File: design/tgtw_ctrl.sv
// Cursor, ring offset and changed flag, with the next-state logic per item.
// Depends on tgtw_pkg; drives the grid command consumed by tgtw_grid.
module tgtw_ctrl #(
  parameter  int unsigned COLUMNS = tgtw_pkg::COLUMNS_DEF,
  parameter  int unsigned ROWS    = tgtw_pkg::ROWS_DEF,
  localparam int unsigned RW      = $clog2(ROWS),
  localparam int unsigned CIW     = $clog2(COLUMNS),
  localparam int unsigned CCW     = $clog2(COLUMNS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [tgtw_pkg::MODE_W-1:0]    mode_i,
  input  logic [tgtw_pkg::BYTE_W-1:0]    byte_i,
  input  logic                           last_i,
  input  logic [RW-1:0]                  rd_row_i,
  input  logic [CIW-1:0]                 rd_col_i,
  output tgtw_pkg::tgtw_gcmd_t           cmd_o,
  output logic [RW-1:0]                  wr_row_o,
  output logic [CIW-1:0]                 wr_col_o,
  output logic [tgtw_pkg::CHAR_W-1:0]    wr_char_o,
  output logic [RW-1:0]                  clr_row_o,
  output logic [RW-1:0]                  rd_prow_o,
  output logic [RW-1:0]                  cursor_row_o,
  output logic [CCW-1:0]                 cursor_col_o,
  output logic                           changed_o
);
  import tgtw_pkg::*;

  localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
  localparam logic [CCW-1:0] COL_END  = CCW'(COLUMNS);

  logic [RW-1:0]  top_q, top_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CCW-1:0] col_q, col_d;
  logic           chg_q, chg_d;

  tgtw_mode_e     mode;
  logic           is_put, is_read, is_ack;
  logic           printable, at_bottom, wrap;
  logic [RW-1:0]  nr_row, nr_top, put_row, put_top;
  logic [CCW-1:0] put_col, tab_clamped;
  logic [CCW:0]   tab_sum, tab_col;
  logic [RW:0]    wr_sum, rd_sum;

  always_comb begin
    mode      = tgtw_mode_e'(mode_i);
    is_put    = fire_i && (mode == MODE_PUT);
    is_read   = fire_i && (mode == MODE_READ);
    is_ack    = fire_i && (mode == MODE_ACK);
    printable = (byte_i >= CH_SPACE) && !byte_i[BYTE_W-1];
    at_bottom = (row_q == LAST_ROW);
    nr_row    = at_bottom ? row_q : row_q + 1'b1;
    nr_top    = at_bottom ? ((top_q == LAST_ROW) ? '0 : top_q + 1'b1) : top_q;

    tab_sum     = {1'b0, col_q} + (CCW+1)'(TAB_STEP);
    tab_col     = {tab_sum[CCW:3], 3'b000};
    tab_clamped = (tab_col > (CCW+1)'(COLUMNS)) ? COL_END : tab_col[CCW-1:0];

    wrap    = (col_q == COL_END);
    put_row = wrap ? nr_row : row_q;
    put_top = wrap ? nr_top : top_q;
    put_col = wrap ? '0 : col_q;

    wr_sum = {1'b0, put_top} + {1'b0, put_row};
    if (wr_sum >= (RW+1)'(ROWS)) begin
      wr_sum = wr_sum - (RW+1)'(ROWS);
    end
    rd_sum = {1'b0, top_q} + {1'b0, rd_row_i};
    if (rd_sum >= (RW+1)'(ROWS)) begin
      rd_sum = rd_sum - (RW+1)'(ROWS);
    end

    top_d  = top_q;
    row_d  = row_q;
    col_d  = col_q;
    chg_d  = chg_q;
    cmd_o    = '0;
    cmd_o.ld = fire_i;

    if (is_put) begin
      unique case (byte_i)
        CH_LF: begin
          row_d = nr_row;
          top_d = nr_top;
          col_d = '0;
          cmd_o.clr_row = at_bottom;
        end
        CH_TAB: begin
          col_d = tab_clamped;
        end
        CH_BS: begin
          if (col_q != '0) begin
            col_d = col_q - 1'b1;
          end
        end
        CH_CR: begin
          col_d = '0;
        end
        CH_FF: begin
          cmd_o.clr_all = 1'b1;
          top_d = '0;
          row_d = '0;
          col_d = '0;
        end
        default: begin
          if (printable) begin
            cmd_o.wr      = 1'b1;
            cmd_o.clr_row = wrap && at_bottom;
            row_d = put_row;
            top_d = put_top;
            col_d = put_col + 1'b1;
          end
        end
      endcase
      if (last_i) begin
        chg_d = 1'b1;
      end
    end

    if (is_read) begin
      cmd_o.rd = ({1'b0, rd_row_i} < (RW+1)'(ROWS)) &&
                 ({1'b0, rd_col_i} < (CIW+1)'(COLUMNS));
    end

    if (is_ack) begin
      chg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      row_q <= '0;
      col_q <= '0;
      chg_q <= 1'b0;
    end else if (fire_i) begin
      top_q <= top_d;
      row_q <= row_d;
      col_q <= col_d;
      chg_q <= chg_d;
    end
  end

  assign wr_row_o     = wr_sum[RW-1:0];
  assign wr_col_o     = put_col[CIW-1:0];
  assign wr_char_o    = byte_i[CHAR_W-1:0];
  assign clr_row_o    = top_q;
  assign rd_prow_o    = rd_sum[RW-1:0];
  assign cursor_row_o = row_q;
  assign cursor_col_o = col_q;
  assign changed_o    = chg_q;

endmodule

// File: design/tgtw_grid.sv
// Character store, per-cell valid bitmap and per-row live flags.
// Depends on tgtw_pkg; driven by the command from tgtw_ctrl.
module tgtw_grid #(
  parameter  int unsigned COLUMNS = tgtw_pkg::COLUMNS_DEF,
  parameter  int unsigned ROWS    = tgtw_pkg::ROWS_DEF,
  localparam int unsigned RW      = $clog2(ROWS),
  localparam int unsigned CIW     = $clog2(COLUMNS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tgtw_pkg::tgtw_gcmd_t        cmd_i,
  input  logic [RW-1:0]               wr_row_i,
  input  logic [CIW-1:0]              wr_col_i,
  input  logic [tgtw_pkg::CHAR_W-1:0] wr_char_i,
  input  logic [RW-1:0]               clr_row_i,
  input  logic [RW-1:0]               rd_row_i,
  input  logic [CIW-1:0]              rd_col_i,
  output logic [tgtw_pkg::CHAR_W-1:0] read_char_o
);
  import tgtw_pkg::*;

  logic [CHAR_W-1:0]  cmem [ROWS][COLUMNS];
  logic [COLUMNS-1:0] vmem [ROWS];

  logic [ROWS-1:0]    flags_q, flags_d, flags_clr;
  logic [COLUMNS-1:0] sel, mask;
  logic               fresh;
  logic               rd_ok_q;
  logic               vbit_q;
  logic [CHAR_W-1:0]  char_q;

  always_comb begin
    flags_clr = cmd_i.clr_all ? '0 : flags_q;
    if (cmd_i.clr_row) begin
      flags_clr[clr_row_i] = 1'b0;
    end
    fresh   = !flags_clr[wr_row_i];
    flags_d = flags_clr;
    if (cmd_i.wr) begin
      flags_d[wr_row_i] = 1'b1;
    end
    sel           = '0;
    sel[wr_col_i] = 1'b1;
    // a dead row is rewritten whole so stale bits drop out
    mask = fresh ? '1 : sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      if (cmd_i.ld) begin
        rd_ok_q <= cmd_i.rd && flags_q[rd_row_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      cmem[wr_row_i][wr_col_i] <= wr_char_i;
      for (int b = 0; b < COLUMNS; b++) begin
        if (mask[b]) begin
          vmem[wr_row_i][b] <= sel[b];
        end
      end
    end
    if (cmd_i.rd) begin
      char_q <= cmem[rd_row_i][rd_col_i];
      vbit_q <= vmem[rd_row_i][rd_col_i];
    end
  end

  assign read_char_o = (rd_ok_q && vbit_q) ? char_q : '0;

endmodule

// File: design/text_grid_terminal_writer_unit.sv
// Top level of the text grid terminal writer: input register and result handshake.
// Depends on tgtw_pkg, tgtw_ctrl and tgtw_grid.
//
// Takes one item per clock cycle unless the result side stalls: the item is
// captured in an input register, its whole cursor and grid update is done as
// it leaves that register, and its result is held in the result registers
// (cursor, changed flag and a registered read of the character memory) until
// transferred. Scrolling and form feed blank rows through per-row live flags,
// so the grid needs no clearing pass after reset or at any other time.
module text_grid_terminal_writer_unit #(
  parameter int unsigned COLUMNS = tgtw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tgtw_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tgtw_pkg::MODE_W-1:0]   mode_i,
  input  logic [tgtw_pkg::BYTE_W-1:0]   byte_in_i,
  input  logic                          last_byte_i,
  input  logic [$clog2(ROWS)-1:0]       read_row_i,
  input  logic [$clog2(COLUMNS)-1:0]    read_col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tgtw_pkg::CHAR_W-1:0]   read_char_o,
  output logic [$clog2(ROWS)-1:0]       cursor_row_o,
  output logic [$clog2(COLUMNS+1)-1:0]  cursor_col_o,
  output logic                          changed_o
);
  import tgtw_pkg::*;

  localparam int unsigned RW  = $clog2(ROWS);
  localparam int unsigned CIW = $clog2(COLUMNS);

  logic              s1_valid_q;
  logic [MODE_W-1:0] mode_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [RW-1:0]     rrow_q;
  logic [CIW-1:0]    rcol_q;
  logic              out_valid_q;
  logic              advance, fire, accept;

  tgtw_gcmd_t        gcmd;
  logic [RW-1:0]     wr_row, clr_row, rd_prow;
  logic [CIW-1:0]    wr_col;
  logic [CHAR_W-1:0] wr_char;

  assign advance    = !(out_valid_q && out_stall_i);
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      byte_q <= byte_in_i;
      last_q <= last_byte_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  tgtw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .mode_i       (mode_q),
    .byte_i       (byte_q),
    .last_i       (last_q),
    .rd_row_i     (rrow_q),
    .rd_col_i     (rcol_q),
    .cmd_o        (gcmd),
    .wr_row_o     (wr_row),
    .wr_col_o     (wr_col),
    .wr_char_o    (wr_char),
    .clr_row_o    (clr_row),
    .rd_prow_o    (rd_prow),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .changed_o    (changed_o)
  );

  tgtw_grid #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_grid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (gcmd),
    .wr_row_i    (wr_row),
    .wr_col_i    (wr_col),
    .wr_char_i   (wr_char),
    .clr_row_i   (clr_row),
    .rd_row_i    (rd_prow),
    .rd_col_i    (rcol_q),
    .read_char_o (read_char_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// File: design/tgtw_checker.sv
// Port-level checks for the text grid terminal writer, bound to the top level.
// Depends on tgtw_pkg for field widths.
module tgtw_checker #(
  parameter int unsigned COLUMNS = tgtw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tgtw_pkg::ROWS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [tgtw_pkg::MODE_W-1:0]   mode_i,
  input logic [tgtw_pkg::BYTE_W-1:0]   byte_in_i,
  input logic                          last_byte_i,
  input logic [$clog2(ROWS)-1:0]       read_row_i,
  input logic [$clog2(COLUMNS)-1:0]    read_col_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tgtw_pkg::CHAR_W-1:0]   read_char_o,
  input logic [$clog2(ROWS)-1:0]       cursor_row_o,
  input logic [$clog2(COLUMNS+1)-1:0]  cursor_col_o,
  input logic                          changed_o
);

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_col_o} <= ($clog2(COLUMNS+1)+1)'(COLUMNS)))
    else $error("cursor column beyond row end");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_row_o} < ($clog2(ROWS)+1)'(ROWS)))
    else $error("cursor row beyond last row");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side can move");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_char_o) &&
      $stable(cursor_row_o) && $stable(cursor_col_o) && $stable(changed_o)))
    else $error("stalled result changed");

endmodule

bind text_grid_terminal_writer_unit tgtw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tgtw_checker (.*);
